// ===== rtl/imu_tcf_pkg.sv =====
// shared types, constants and the cordic step-angle table for the tilt filter
// no dependencies; used by every rtl file through scoped names
package imu_tcf_pkg;

  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
  } angle_t;

  localparam int          MUL_W        = 32;
  localparam int          ADDR_W       = 2;
  localparam logic [ADDR_W-1:0] REG_YAW_BIAS = 2'd0;

  // 2^32 * 16 * 180 / (1000 * pi): q4.12 rad/s times ms into q16.16 degrees
  localparam logic [31:0] KDEG         = 32'd3937335988;
  localparam int          CORDIC_STEPS = 16;
  localparam int          SQRT_STEPS   = 24;
  localparam int          DIV_BITS     = 7;
  localparam int          DIV_STEPS    = 5;

  function automatic logic signed [31:0] atan_step(input logic [3:0] i);
    logic signed [31:0] v;
    case (i)
      4'd0:  v = 32'sd2949120;
      4'd1:  v = 32'sd1740967;
      4'd2:  v = 32'sd919879;
      4'd3:  v = 32'sd466945;
      4'd4:  v = 32'sd234378;
      4'd5:  v = 32'sd117304;
      4'd6:  v = 32'sd58666;
      4'd7:  v = 32'sd29335;
      4'd8:  v = 32'sd14668;
      4'd9:  v = 32'sd7334;
      4'd10: v = 32'sd3667;
      4'd11: v = 32'sd1833;
      4'd12: v = 32'sd917;
      4'd13: v = 32'sd458;
      4'd14: v = 32'sd229;
      default: v = 32'sd115;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/imu_tcf_mul.sv =====
// shared unsigned multiplier with registered product
// depends on imu_tcf_pkg for the operand width
module imu_tcf_mul (
  input  logic                               clk,
  input  logic [imu_tcf_pkg::MUL_W-1:0]      a,
  input  logic [imu_tcf_pkg::MUL_W-1:0]      b,
  output logic [2*imu_tcf_pkg::MUL_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/imu_tilt_complementary_filter_core.sv =====
// complementary tilt filter core: sequencer, sqrt, cordic, divide-by-ten datapath
// depends on imu_tcf_pkg and imu_tcf_mul
//
//   channel  | dir | handshake                    | beat
//   sample   | in  | sample_valid / sample_stall  | imu_tcf_pkg::sample_t
//   angle    | out | angle_valid  / angle_stall   | imu_tcf_pkg::angle_t
//   apb      | in  | psel / penable / pready      | yaw_rate_bias at byte 0
//
// a sample keeps the sequencer busy from its beat until its result is loaded, and the
// work includes two 24-step square roots and two 16-step cordic runs;
// a zero numerator skips its root and cordic, a saturating blend skips its divide
// sample_stall is high from acceptance until the result is loaded into the output register
// a new sample is taken while an earlier result still waits on angle_stall
// rst is synchronous; it clears the timestamp, the three angles and the bias
module imu_tilt_complementary_filter_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  imu_tcf_pkg::sample_t                  sample,
  output logic                                  angle_valid,
  input  logic                                  angle_stall,
  output imu_tcf_pkg::angle_t                   angle,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [imu_tcf_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SQ_B   = 5'd1;
  localparam logic [4:0] ST_SQ_C   = 5'd2;
  localparam logic [4:0] ST_SQ_SUM = 5'd3;
  localparam logic [4:0] ST_SQRT   = 5'd4;
  localparam logic [4:0] ST_CORD   = 5'd5;
  localparam logic [4:0] ST_G1     = 5'd6;
  localparam logic [4:0] ST_G2     = 5'd7;
  localparam logic [4:0] ST_G3     = 5'd8;
  localparam logic [4:0] ST_G4     = 5'd9;
  localparam logic [4:0] ST_B1     = 5'd10;
  localparam logic [4:0] ST_B2     = 5'd11;
  localparam logic [4:0] ST_B3     = 5'd12;
  localparam logic [4:0] ST_B4     = 5'd13;
  localparam logic [4:0] ST_DIV    = 5'd14;
  localparam logic [4:0] ST_Y1     = 5'd15;
  localparam logic [4:0] ST_Y2     = 5'd16;
  localparam logic [4:0] ST_FIN    = 5'd17;

  localparam logic [55:0] SAT_POS_LIM = 56'd21474836480;
  localparam logic [55:0] SAT_NEG_LIM = 56'd21474836490;
  localparam logic signed [50:0] T_MAX = 51'sd2147483647;
  localparam logic signed [50:0] T_MIN = -51'sd2147483648;

  logic [4:0]                 state;
  logic [1:0]                 sel;
  logic [4:0]                 cnt;
  imu_tcf_pkg::sample_t       smp;
  logic [31:0]                dt;
  logic [31:0]                last_time;
  logic signed [31:0]         roll_acc, pitch_acc, yaw_acc;
  logic signed [15:0]         bias;
  logic [31:0]                s_sum;
  logic [47:0]                sq_n, sq_res, sq_bit;
  logic signed [26:0]         cx, cy;
  logic signed [31:0]         cz;
  logic signed [31:0]         rref, pref;
  logic                       neg;
  logic [48:0]                mreg;
  logic [31:0]                rnd;
  logic signed [49:0]         inc [3];
  logic signed [50:0]         tsum;
  logic signed [55:0]         nsum;
  logic [55:0]                mm;
  logic                       bneg;
  logic [34:0]                dq;
  logic [3:0]                 rem;

  logic [imu_tcf_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*imu_tcf_pkg::MUL_W-1:0] prod;

  imu_tcf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // operand selection for the reference angle and the gyro rate of the current axis
  logic signed [15:0] ra, rb, rc;
  logic [16:0]        babs, cabs;
  logic signed [16:0] rate17;
  logic [16:0]        rabs;

  always_comb begin
    ra = sel[0] ? smp.accel_y : smp.accel_x;
    rb = sel[0] ? smp.accel_x : smp.accel_y;
    rc = smp.accel_z;
    babs = rb[15] ? 17'(-{rb[15], rb}) : 17'({rb[15], rb});
    cabs = rc[15] ? 17'(-{rc[15], rc}) : 17'({rc[15], rc});
    case (sel)
      2'd0:    rate17 = {smp.rate_x[15], smp.rate_x};
      2'd1:    rate17 = {smp.rate_y[15], smp.rate_y};
      default: rate17 = {smp.rate_z[15], smp.rate_z} - {bias[15], bias};
    endcase
    rabs = rate17[16] ? 17'(-rate17) : 17'(rate17);
  end

  always_comb begin
    case (state)
      ST_SQ_B: begin
        mul_a = {15'd0, babs};
        mul_b = {15'd0, babs};
      end
      ST_SQ_C: begin
        mul_a = {15'd0, cabs};
        mul_b = {15'd0, cabs};
      end
      ST_G1: begin
        mul_a = {15'd0, rabs};
        mul_b = dt;
      end
      ST_G2: begin
        mul_a = prod[31:0];
        mul_b = imu_tcf_pkg::KDEG;
      end
      ST_G3: begin
        mul_a = {15'd0, mreg[48:32]};
        mul_b = imu_tcf_pkg::KDEG;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step, one result bit per cycle
  logic [48:0] sq_trial;
  logic        sq_take;
  logic [47:0] sq_res_next;
  logic [31:0] s_total;

  always_comb begin
    s_total     = s_sum + prod[31:0];
    sq_trial    = {1'b0, sq_res} + {1'b0, sq_bit};
    sq_take     = {1'b0, sq_n} >= sq_trial;
    sq_res_next = sq_take ? (sq_res >> 1) + sq_bit : (sq_res >> 1);
  end

  // cordic vectoring step
  logic signed [26:0] xs, ys, cx_next, cy_next;
  logic signed [31:0] cz_next, ang;

  always_comb begin
    xs  = cx >>> cnt[3:0];
    ys  = cy >>> cnt[3:0];
    ang = imu_tcf_pkg::atan_step(cnt[3:0]);
    if (cy > 27'sd0) begin
      cx_next = cx + ys;
      cy_next = cy - xs;
      cz_next = cz + ang;
    end else begin
      cx_next = cx - ys;
      cy_next = cy + xs;
      cz_next = cz - ang;
    end
  end

  // gyro increment tail and blend operands
  logic [64:0]        rnd_sum;
  logic [48:0]        r_mag;
  logic signed [49:0] inc_val;
  logic signed [31:0] b_acc, b_ref;
  logic signed [55:0] t56;
  logic [55:0]        n_abs;

  always_comb begin
    rnd_sum = {1'b0, prod} + 65'h0_8000_0000;
    r_mag   = prod[48:0] + {17'd0, rnd};
    inc_val = neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    b_acc   = sel[0] ? pitch_acc : roll_acc;
    b_ref   = sel[0] ? pref : rref;
    t56     = {{5{tsum[50]}}, tsum};
    n_abs   = nsum[55] ? 56'(-nsum) : 56'(nsum);
  end

  // divide by ten, seven quotient bits a cycle
  logic [3:0]  rem_next;
  logic [6:0]  qbits;
  logic [34:0] dq_next;
  logic [4:0]  r5;
  logic signed [31:0] q_signed;

  always_comb begin
    rem_next = rem;
    qbits    = '0;
    r5       = '0;
    for (int j = 0; j < imu_tcf_pkg::DIV_BITS; j++) begin
      r5 = {rem_next, dq[34-j]};
      if (r5 >= 5'd10) begin
        r5 = r5 - 5'd10;
        qbits[6-j] = 1'b1;
      end
      rem_next = r5[3:0];
    end
    dq_next  = {dq[27:0], qbits};
    q_signed = bneg ? -$signed(dq_next[31:0]) : $signed(dq_next[31:0]);
  end

  logic signed [31:0] ysat;
  always_comb begin
    if (tsum > T_MAX)      ysat = 32'sh7fffffff;
    else if (tsum < T_MIN) ysat = 32'sh80000000;
    else                   ysat = tsum[31:0];
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{16{bias[15]}}, bias};

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (psel && penable && pwrite && paddr == imu_tcf_pkg::REG_YAW_BIAS) begin
      bias <= pwdata[15:0];
    end
  end

  assign sample_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sel         <= '0;
      cnt         <= '0;
      last_time   <= '0;
      roll_acc    <= '0;
      pitch_acc   <= '0;
      yaw_acc     <= '0;
      angle_valid <= 1'b0;
    end else begin
      // the final step reloads the output beat itself
      if (angle_valid && !angle_stall && state != ST_FIN) begin
        angle_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            smp       <= sample;
            dt        <= sample.time_ms - last_time;
            last_time <= sample.time_ms;
            sel       <= 2'd0;
            state     <= ST_SQ_B;
          end
        end
        ST_SQ_B: state <= ST_SQ_C;
        ST_SQ_C: begin
          s_sum <= prod[31:0];
          state <= ST_SQ_SUM;
        end
        ST_SQ_SUM: begin
          if (ra == 16'sd0) begin
            // zero numerator gives a level reference
            if (sel[0]) begin
              pref  <= '0;
              sel   <= 2'd0;
              state <= ST_G1;
            end else begin
              rref  <= '0;
              sel   <= 2'd1;
              state <= ST_SQ_B;
            end
          end else begin
            sq_n   <= {s_total, 16'd0};
            sq_res <= '0;
            sq_bit <= 48'd1 << 46;
            cnt    <= '0;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_take) sq_n <= sq_n - sq_trial[47:0];
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (cnt == 5'(imu_tcf_pkg::SQRT_STEPS - 1)) begin
            cx    <= {3'd0, sq_res_next[23:0]};
            cy    <= {{3{ra[15]}}, ra, 8'd0};
            cz    <= '0;
            cnt   <= '0;
            state <= ST_CORD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_CORD: begin
          cx  <= cx_next;
          cy  <= cy_next;
          cz  <= cz_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(imu_tcf_pkg::CORDIC_STEPS - 1)) begin
            if (sel[0]) begin
              pref  <= cz_next;
              sel   <= 2'd0;
              state <= ST_G1;
            end else begin
              rref  <= cz_next;
              sel   <= 2'd1;
              state <= ST_SQ_B;
            end
          end
        end
        ST_G1: begin
          neg   <= rate17[16];
          state <= ST_G2;
        end
        ST_G2: begin
          mreg  <= prod[48:0];
          state <= ST_G3;
        end
        ST_G3: begin
          rnd   <= rnd_sum[63:32];
          state <= ST_G4;
        end
        ST_G4: begin
          inc[sel] <= inc_val;
          if (sel == 2'd2) begin
            sel   <= 2'd0;
            state <= ST_B1;
          end else begin
            sel   <= sel + 2'd1;
            state <= ST_G1;
          end
        end
        ST_B1: begin
          tsum  <= {{19{b_acc[31]}}, b_acc} + {inc[sel][49], inc[sel]};
          state <= ST_B2;
        end
        ST_B2: begin
          nsum  <= (t56 <<< 3) + t56 + {{24{b_ref[31]}}, b_ref};
          state <= ST_B3;
        end
        ST_B3: begin
          bneg  <= nsum[55];
          mm    <= n_abs + 56'd5;
          state <= ST_B4;
        end
        ST_B4: begin
          if (!bneg && mm >= SAT_POS_LIM) begin
            if (sel[0]) pitch_acc <= 32'sh7fffffff;
            else        roll_acc  <= 32'sh7fffffff;
            sel   <= sel + 2'd1;
            state <= sel[0] ? ST_Y1 : ST_B1;
          end else if (bneg && mm >= SAT_NEG_LIM) begin
            if (sel[0]) pitch_acc <= 32'sh80000000;
            else        roll_acc  <= 32'sh80000000;
            sel   <= sel + 2'd1;
            state <= sel[0] ? ST_Y1 : ST_B1;
          end else begin
            dq    <= mm[34:0];
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(imu_tcf_pkg::DIV_STEPS - 1)) begin
            if (sel[0]) pitch_acc <= q_signed;
            else        roll_acc  <= q_signed;
            sel   <= sel + 2'd1;
            state <= sel[0] ? ST_Y1 : ST_B1;
          end
        end
        ST_Y1: begin
          tsum  <= {{19{yaw_acc[31]}}, yaw_acc} + {inc[2][49], inc[2]};
          state <= ST_Y2;
        end
        ST_Y2: begin
          yaw_acc <= ysat;
          state   <= ST_FIN;
        end
        ST_FIN: begin
          if (!angle_valid || !angle_stall) begin
            angle.roll_deg  <= roll_acc;
            angle.pitch_deg <= pitch_acc;
            angle.yaw_deg   <= yaw_acc;
            angle_valid     <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(angle_valid) |-> $past(state) == ST_FIN)
    else $error("result beat raised outside the final step");

  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT |-> $onehot(sq_bit))
    else $error("square root trial bit lost");

  a_cordic_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> cnt < 5'(imu_tcf_pkg::CORDIC_STEPS))
    else $error("cordic ran past its last step");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt < 5'(imu_tcf_pkg::DIV_STEPS))
    else $error("divider ran past its last step");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !angle_stall) |=> (state == ST_IDLE && angle_valid))
    else $error("finished result not loaded");

endmodule
